### design/cbf_pkg.sv
package cbf_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int BOX_BITS   = 6 * COORD_BITS;
  localparam int TDATA_W    = ((BOX_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  typedef struct packed {
    vec3_t hi;
    vec3_t lo;
  } box_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    box_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic vld;
    box_t box;
    logic eor;
    logic empty;
    logic ovf;
  } res_t;

  function automatic coord_t cmin(coord_t a, coord_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return ($signed(a) < $signed(b)) ? b : a;
  endfunction

  function automatic box_t order_box(vec3_t a, vec3_t b);
    box_t r;
    r.lo.x = cmin(a.x, b.x);
    r.lo.y = cmin(a.y, b.y);
    r.lo.z = cmin(a.z, b.z);
    r.hi.x = cmax(a.x, b.x);
    r.hi.y = cmax(a.y, b.y);
    r.hi.z = cmax(a.z, b.z);
    return r;
  endfunction

  // true when box i lies within box k on all three axes
  function automatic logic box_inside(box_t i, box_t k);
    return ($signed(i.lo.x) >= $signed(k.lo.x)) && ($signed(i.hi.x) <= $signed(k.hi.x)) &&
           ($signed(i.lo.y) >= $signed(k.lo.y)) && ($signed(i.hi.y) <= $signed(k.hi.y)) &&
           ($signed(i.lo.z) >= $signed(k.lo.z)) && ($signed(i.hi.z) <= $signed(k.hi.z));
  endfunction

endpackage

### design/contained_box_filter_unit.sv
// Box containment filter.
// Input channel (in_*): one box per transaction, two corners in signed Q8.8;
// in_tlast marks the final box of a set. Boxes load at one per cycle into a
// 64-entry box memory (min/max corners ordered on the way in). Boxes past the
// store size are dropped and flagged on every result of that set.
// After the last box the engine runs the pairwise pass: per box i it reads i
// (S_RDI, S_CAPI), sweeps all n stored boxes through the single memory read
// port (S_SCAN) and decides (S_DEC). in_tready is low during the pass.
// Output channel (out_*): surviving boxes in load order, out_tlast on the
// final one; a set with no survivor gives one all-zero result with
// nothing_kept set. A survivor is held back until the next one is found so
// that out_tlast is known; one output register sits between engine and port.
// A stalled receiver simply holds the engine in place; nothing is lost.
// Reset (rst_n low, synchronous) empties the set and drops any pending result.
module contained_box_filter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z
  input  logic [cbf_pkg::TDATA_W-1:0]   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z
  output logic [cbf_pkg::TDATA_W-1:0]   out_tdata,
  output logic                          out_tlast,
  // nothing_kept, store_overflow
  output logic [1:0]                    out_tuser
);
  import cbf_pkg::*;

  vec3_t            corner_a, corner_b;
  ram_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  box_t             rdata;
  res_t             push;
  res_t             out_r, out_nxt;
  logic             out_free;

  assign corner_a.x = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign corner_a.y = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign corner_a.z = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign corner_b.x = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign corner_b.y = in_tdata[4*COORD_BITS +: COORD_BITS];
  assign corner_b.z = in_tdata[5*COORD_BITS +: COORD_BITS];

  cbf_box_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  cbf_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .corner_a (corner_a),
    .corner_b (corner_b),
    .in_last  (in_tlast),
    .wr       (wr),
    .raddr    (raddr),
    .rdata    (rdata),
    .push     (push),
    .out_free (out_free)
  );

  assign out_free = !out_r.vld || out_tready;

  always_comb begin
    out_nxt = out_r;
    if (push.vld) begin
      out_nxt = push;
    end else if (out_tready) begin
      out_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= out_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r.box   <= out_nxt.box;
    out_r.eor   <= out_nxt.eor;
    out_r.empty <= out_nxt.empty;
    out_r.ovf   <= out_nxt.ovf;
  end

  assign out_tvalid = out_r.vld;
  assign out_tdata  = TDATA_W'({out_r.box.hi.z, out_r.box.hi.y, out_r.box.hi.x,
                                out_r.box.lo.z, out_r.box.lo.y, out_r.box.lo.x});
  assign out_tlast  = out_r.eor;
  assign out_tuser  = {out_r.ovf, out_r.empty};

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("empty result not marked end of run");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("empty result carries coordinates");

  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted during filter pass");

  a_no_push_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> out_free)
    else $error("result pushed into occupied output register");

endmodule

### design/cbf_box_ram.sv
module cbf_box_ram (
  input  logic                    clk,
  input  cbf_pkg::ram_wr_t        wr,
  input  logic [cbf_pkg::IDX_W-1:0] raddr,
  output cbf_pkg::box_t           rdata
);
  import cbf_pkg::*;

  box_t mem [MAX_BOXES];
  box_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/cbf_engine.sv
module cbf_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cbf_pkg::vec3_t            corner_a,
  input  cbf_pkg::vec3_t            corner_b,
  input  logic                      in_last,
  output cbf_pkg::ram_wr_t          wr,
  output logic [cbf_pkg::IDX_W-1:0] raddr,
  input  cbf_pkg::box_t             rdata,
  output cbf_pkg::res_t             push,
  input  logic                      out_free
);
  import cbf_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_RDI   = 6'b000010,
    S_CAPI  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DEC   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] cmpk_r, cmpk_nxt;
  logic             cmpv_r, cmpv_nxt;
  logic             kill_r, kill_nxt;
  logic             pend_r, pend_nxt;
  box_t             boxi_r, boxi_nxt;
  box_t             pbox_r, pbox_nxt;
  logic             hit, keep;

  assign hit  = cmpv_r && (cmpk_r != i_r) && box_inside(boxi_r, rdata);
  assign keep = !(kill_r || hit);

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    cmpk_nxt  = cmpk_r;
    cmpv_nxt  = cmpv_r;
    kill_nxt  = kill_r | hit;
    pend_nxt  = pend_r;
    boxi_nxt  = boxi_r;
    pbox_nxt  = pbox_r;
    in_ready  = 1'b0;
    raddr     = '0;
    wr.en     = 1'b0;
    wr.addr   = count_r[IDX_W-1:0];
    wr.data   = order_box(corner_a, corner_b);
    push      = '0;

    unique case (st_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_BOXES)) begin
            wr.en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt  = '0;
            st_nxt = (count_nxt == '0) ? S_FLUSH : S_RDI;
          end
        end
      end
      S_RDI: begin
        raddr  = i_r[IDX_W-1:0];
        st_nxt = S_CAPI;
      end
      S_CAPI: begin
        boxi_nxt = rdata;
        k_nxt    = '0;
        kill_nxt = 1'b0;
        cmpv_nxt = 1'b0;
        st_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (k_r < count_r) begin
          raddr    = k_r[IDX_W-1:0];
          k_nxt    = k_r + CNT_W'(1);
          cmpk_nxt = k_r;
          cmpv_nxt = 1'b1;
        end else begin
          cmpv_nxt = 1'b0;
          st_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmpv_nxt = 1'b0;
        if (!(keep && pend_r && !out_free)) begin
          if (keep) begin
            if (pend_r) begin
              push.vld = 1'b1;
              push.box = pbox_r;
              push.ovf = ovf_r;
            end
            pbox_nxt = boxi_r;
            pend_nxt = 1'b1;
          end
          if ((i_r + CNT_W'(1)) < count_r) begin
            i_nxt  = i_r + CNT_W'(1);
            st_nxt = S_RDI;
          end else begin
            st_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push.vld   = 1'b1;
          push.box   = pend_r ? pbox_r : '0;
          push.eor   = 1'b1;
          push.empty = !pend_r;
          push.ovf   = ovf_r;
          pend_nxt   = 1'b0;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          st_nxt     = S_LOAD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      cmpv_r  <= 1'b0;
      pend_r  <= 1'b0;
      kill_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      cmpv_r  <= cmpv_nxt;
      pend_r  <= pend_nxt;
      kill_r  <= kill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    cmpk_r <= cmpk_nxt;
    boxi_r <= boxi_nxt;
    pbox_r <= pbox_nxt;
  end

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbf_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_ITEMS = 95;
  localparam int CB           = COORD_BITS;

  typedef struct {
    box_t bx;
    bit   eor;
    bit   none_kept;
    bit   ovf;
  } survivor_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic [1:0]         out_tuser;

  bit        gaps_on = 1'b1;
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  box_t      held_boxes[$];
  bit        set_overflowed = 1'b0;
  survivor_t survivor_q[$];

  contained_box_filter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Predictor: stores ordered boxes, culls enclosed ones on the last box.
  function automatic void absorb_box(vec3_t a, vec3_t b, bit last);
    box_t      bx;
    survivor_t s;
    int        kept[$];
    bit        keep;
    if (held_boxes.size() < MAX_BOXES) begin
      bx.lo.x = (a.x < b.x) ? a.x : b.x;
      bx.lo.y = (a.y < b.y) ? a.y : b.y;
      bx.lo.z = (a.z < b.z) ? a.z : b.z;
      bx.hi.x = (a.x < b.x) ? b.x : a.x;
      bx.hi.y = (a.y < b.y) ? b.y : a.y;
      bx.hi.z = (a.z < b.z) ? b.z : a.z;
      held_boxes.insert(held_boxes.size(), bx);
    end else begin
      set_overflowed = 1'b1;
    end
    if (!last) return;
    foreach (held_boxes[i]) begin
      keep = 1'b1;
      foreach (held_boxes[k]) begin
        if (k != i &&
            held_boxes[i].lo.x >= held_boxes[k].lo.x && held_boxes[i].hi.x <= held_boxes[k].hi.x &&
            held_boxes[i].lo.y >= held_boxes[k].lo.y && held_boxes[i].hi.y <= held_boxes[k].hi.y &&
            held_boxes[i].lo.z >= held_boxes[k].lo.z && held_boxes[i].hi.z <= held_boxes[k].hi.z)
          keep = 1'b0;
      end
      if (keep) kept.insert(kept.size(), i);
    end
    s.ovf = set_overflowed;
    s.none_kept = 1'b0;
    if (kept.size() == 0) begin
      s.bx = '0;
      s.eor = 1'b1;
      s.none_kept = 1'b1;
      survivor_q.insert(survivor_q.size(), s);
    end else begin
      foreach (kept[j]) begin
        s.bx = held_boxes[kept[j]];
        s.eor = (j == kept.size() - 1);
        survivor_q.insert(survivor_q.size(), s);
      end
    end
    held_boxes.delete();
    set_overflowed = 1'b0;
  endfunction

  function automatic vec3_t v3(int x, int y, int z);
    vec3_t v;
    v.x = x[CB-1:0];
    v.y = y[CB-1:0];
    v.z = z[CB-1:0];
    return v;
  endfunction

  // New box for a set: random, or derived from one already in the set so that
  // containment, duplicates and near misses show up often.
  function automatic box_t draw_box(box_t drawn[$]);
    box_t bx;
    box_t seed_bx;
    int   mode;
    int   p, q, t, rlo, rhi;
    mode = $urandom_range(99);
    if (drawn.size() == 0) begin
      mode = $urandom_range(1) ? 0 : 95;
      seed_bx = '0;
    end else begin
      seed_bx = drawn[$urandom_range(drawn.size() - 1)];
    end
    for (int ax = 0; ax < 3; ax++) begin
      rlo = int'($signed(seed_bx.lo[ax*CB +: CB]));
      rhi = int'($signed(seed_bx.hi[ax*CB +: CB]));
      if (mode < 20) begin
        p = int'($urandom_range(65535)) - 32768;
        q = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) == 0) p = $urandom_range(1) ? 32767 : -32768;
        if ($urandom_range(9) == 0) q = $urandom_range(1) ? 32767 : -32768;
        if (p > q) begin
          t = p;
          p = q;
          q = t;
        end
      end else if (mode < 40) begin
        p = rlo;
        q = rhi;
      end else if (mode < 70) begin
        p = rlo + int'($urandom_range(rhi - rlo));
        q = p + int'($urandom_range(rhi - p));
      end else if (mode < 85) begin
        p = rlo - int'($urandom_range(400));
        q = rhi + int'($urandom_range(400));
        if (p < -32768) p = -32768;
        if (q > 32767) q = 32767;
      end else begin
        p = int'($urandom_range(1024)) - 512;
        q = ($urandom_range(3) == 0) ? p : p + int'($urandom_range(300));
      end
      bx.lo[ax*CB +: CB] = p[CB-1:0];
      bx.hi[ax*CB +: CB] = q[CB-1:0];
    end
    return bx;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", what, got, want));
  endtask

  task automatic send_box(vec3_t a, vec3_t b, bit last);
    while (gaps_on && $urandom_range(99) < 25) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_box(a, b, last);
  endtask

  // corners swapped at random per axis
  task automatic send_shuffled(box_t bx, bit last);
    vec3_t a;
    vec3_t b;
    a = bx.lo;
    b = bx.hi;
    for (int ax = 0; ax < 3; ax++) begin
      if ($urandom_range(1)) begin
        a[ax*CB +: CB] = bx.hi[ax*CB +: CB];
        b[ax*CB +: CB] = bx.lo[ax*CB +: CB];
      end
    end
    send_box(a, b, last);
  endtask

  task automatic test_single_box();
    send_box(v3(-32768, 32767, -32768), v3(32767, -32768, 32767), 1'b1);
    send_box(v3(32767, -1, 0), v3(-32768, 0, -1), 1'b1);
    send_box(v3(0, 0, 0), v3(0, 0, 0), 1'b1);
    send_box(v3(-1, -1, -1), v3(-1, -1, -1), 1'b1);
  endtask

  task automatic test_nesting();
    send_box(v3(-1000, -1000, -1000), v3(1000, 1000, 1000), 1'b0);
    send_box(v3(10, 10, 10), v3(-10, -10, -10), 1'b0);
    send_box(v3(-1000, -1000, 0), v3(0, 1000, 1000), 1'b0);
    send_box(v3(2000, 2000, 2000), v3(3000, 3000, 3000), 1'b0);
    send_box(v3(500, 500, 500), v3(1500, 1500, 1500), 1'b1);
    // last loaded box is culled, end of run moves to the one before
    send_box(v3(-5000, -5000, -5000), v3(5000, 5000, 5000), 1'b0);
    send_box(v3(6000, 0, 0), v3(7000, 100, 100), 1'b0);
    send_box(v3(-5000, 0, 4999), v3(5000, 1, 5000), 1'b1);
  endtask

  task automatic test_duplicates();
    send_box(v3(-300, 40, 7), v3(200, -90, 8), 1'b0);
    send_box(v3(200, -90, 8), v3(-300, 40, 7), 1'b1);
    send_box(v3(1, 2, 3), v3(4, 5, 6), 1'b0);
    send_box(v3(1, 2, 3), v3(4, 5, 6), 1'b0);
    send_box(v3(0, 0, 0), v3(4, 5, 6), 1'b1);
    // flat boxes: one on a face of another, one alone
    send_box(v3(-100, -100, -100), v3(100, 100, 100), 1'b0);
    send_box(v3(-100, -50, 100), v3(100, 50, 100), 1'b0);
    send_box(v3(300, 300, 300), v3(400, 300, 400), 1'b1);
  endtask

  task automatic test_capacity();
    box_t drawn[$];
    box_t bx;
    for (int j = 0; j < MAX_BOXES; j++) begin
      bx = draw_box(drawn);
      drawn.insert(drawn.size(), bx);
      send_shuffled(bx, j == MAX_BOXES - 1);
    end
    drawn.delete();
    for (int j = 0; j < MAX_BOXES + 2; j++) begin
      bx = draw_box(drawn);
      drawn.insert(drawn.size(), bx);
      send_shuffled(bx, j == MAX_BOXES + 1);
    end
    // full store of identical boxes, last box dropped: empty result with overflow
    bx = draw_box(drawn);
    for (int j = 0; j <= MAX_BOXES; j++) send_shuffled(bx, j == MAX_BOXES);
  endtask

  task automatic test_random_sets();
    box_t drawn[$];
    box_t bx;
    int   sent;
    int   set_len;
    int   pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75)      set_len = $urandom_range(6, 1);
      else if (pick < 92) set_len = $urandom_range(20, 7);
      else if (pick < 97) set_len = $urandom_range(MAX_BOXES, 30);
      else                set_len = $urandom_range(MAX_BOXES + 8, MAX_BOXES + 1);
      drawn.delete();
      for (int j = 0; j < set_len; j++) begin
        gaps_on = !(sent >= 20 && sent < 70);
        bx = draw_box(drawn);
        drawn.insert(drawn.size(), bx);
        send_shuffled(bx, j == set_len - 1);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin : check_results
    survivor_t want;
    box_t      got;
    if (rst_n && out_tvalid && out_tready) begin
      if (survivor_q.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = survivor_q.pop_front();
        got = box_t'(out_tdata);
        check_field("min_x", got.lo.x, want.bx.lo.x);
        check_field("min_y", got.lo.y, want.bx.lo.y);
        check_field("min_z", got.lo.z, want.bx.lo.z);
        check_field("max_x", got.hi.x, want.bx.hi.x);
        check_field("max_y", got.hi.y, want.bx.hi.y);
        check_field("max_z", got.hi.z, want.bx.hi.z);
        check_field("end_of_run", out_tlast, want.eor);
        check_field("nothing_kept", out_tuser[0], want.none_kept);
        check_field("store_overflow", out_tuser[1], want.ovf);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_single_box();
    test_nesting();
    test_duplicates();
    test_capacity();
    test_random_sets();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (survivor_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
